[src/bir_pkg.sv]
// types and constants shared by the bilinear resize modules
// depends on nothing; imported by the front, back and top level
`default_nettype none
package bir_pkg;
   localparam int TW = 38;
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_REQ  = 1'b1;
   localparam logic [1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_X_SCALE    = 2'd2;
   localparam logic [1:0] CSR_Y_SCALE    = 2'd3;
   // half a pixel in 2^-17 units
   localparam logic [TW-1:0] HALF_BIAS = TW'(65536);
   localparam logic [16:0] WEIGHT_ONE = 17'd65536;
   localparam logic [42:0] ROUND_HALF = 43'h0_8000_0000;

   typedef struct packed {
      logic          kind;
      logic          ok;
      logic [11:0]   col;
      logic [11:0]   row;
      logic [1:0]    chan;
      logic [7:0]    pix;
      logic [TW-1:0] tx;
      logic [TW-1:0] ty;
   } bir_item_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] pixel;
   } bir_result_type;
endpackage
`default_nettype wire

[src/bir_queue.sv]
// small register queue used between front and back and for results
// no package dependencies
`default_nettype none
module bir_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  wire [WIDTH-1:0]              push_data,
   input  wire                          pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in = push ? PW'(wr_ff + PW'(1)) : wr_ff;
      rd_in = pop ? PW'(rd_ff + PW'(1)) : rd_ff;
      cnt_in = CW'(cnt_ff + CW'(push) - CW'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= push_data;
   end

   assign pop_data = slot_ff[rd_ff];
   assign count = cnt_ff;
endmodule
`default_nettype wire

[src/bir_front.sv]
// front end: registers an accepted item, maps destination coordinates
// to source positions and checks ranges; uses bir_pkg
`default_nettype none
module bir_front #(
   parameter int MAX_SRC_WIDTH = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int CHANNELS = 3
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 accept,
   input  wire                 kind,
   input  wire [11:0]          col,
   input  wire [11:0]          row,
   input  wire [1:0]           chan,
   input  wire [7:0]           pix,
   input  wire [23:0]          x_scale,
   input  wire [23:0]          y_scale,
   output logic                item_valid,
   output bir_pkg::bir_item_type item
);
   import bir_pkg::*;
   logic valid_ff;
   bir_item_type item_ff, item_in;
   logic in_range;

   always_comb begin
      in_range = ({1'b0, col} < 13'(MAX_SRC_WIDTH)) && ({1'b0, row} < 13'(MAX_SRC_HEIGHT));
      item_in.kind = kind;
      item_in.ok = ({1'b0, chan} < 3'(CHANNELS)) && (kind == KIND_REQ || in_range);
      item_in.col = col;
      item_in.row = row;
      item_in.chan = chan;
      item_in.pix = pix;
      // (2*col+1)*scale + half, in 2^-17 units, offset by one pixel
      item_in.tx = TW'({col, 1'b1} * x_scale) + HALF_BIAS;
      item_in.ty = TW'({row, 1'b1} * y_scale) + HALF_BIAS;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= accept;
      if (accept) item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item = item_ff;
endmodule
`default_nettype wire

[src/bir_back.sv]
// back end: pixel store (two copies, two read ports each), weights,
// products and rounding; uses bir_pkg
`default_nettype none
module bir_back #(
   parameter int MAX_SRC_WIDTH = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int CHANNELS = 3
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   item_valid,
   input  bir_pkg::bir_item_type item,
   input  wire [8:0]             src_w,
   input  wire [8:0]             src_h,
   output bir_pkg::bir_result_type result,
   output logic [1:0]            inflight
);
   import bir_pkg::*;
   localparam int CW = $clog2(MAX_SRC_WIDTH);
   localparam int RW = $clog2(MAX_SRC_HEIGHT);
   localparam int DEPTH = CHANNELS << (RW + CW);
   localparam int AW = $clog2(DEPTH);

   logic [7:0] mem_a_ff [DEPTH];
   logic [7:0] mem_b_ff [DEPTH];

   logic [20:0] ix, iy;
   logic [CW-1:0] xa, xb;
   logic [RW-1:0] ya, yb;
   logic [16:0] fx, fy, gx, gy;
   logic [1:0] ch_rd;
   logic is_req, do_load;
   logic [AW-1:0] wr_addr;

   logic s1_v_ff, s1_ok_ff, s2_v_ff, s2_ok_ff;
   logic [32:0] w00_ff, w01_ff, w10_ff, w11_ff;
   logic [7:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [40:0] m00_ff, m01_ff, m10_ff, m11_ff;
   logic [42:0] sum;
   logic [10:0] res;

   function automatic logic [AW-1:0] mk_addr(input logic [1:0] c, input logic [RW-1:0] r,
                                             input logic [CW-1:0] x);
      return AW'({c, r, x});
   endfunction

   always_comb begin
      ix = item.tx[TW-1:17];
      iy = item.ty[TW-1:17];
      // ix is the floor plus one; clamp floor and floor+1 to the edges
      xb = (ix >= 21'(src_w)) ? CW'(src_w - 9'd1) : CW'(ix);
      xa = (ix == 21'd0) ? '0 : (ix > 21'(src_w)) ? CW'(src_w - 9'd1) : CW'(ix - 21'd1);
      yb = (iy >= 21'(src_h)) ? RW'(src_h - 9'd1) : RW'(iy);
      ya = (iy == 21'd0) ? '0 : (iy > 21'(src_h)) ? RW'(src_h - 9'd1) : RW'(iy - 21'd1);
      fx = {1'b0, item.tx[16:1]};
      fy = {1'b0, item.ty[16:1]};
      gx = WEIGHT_ONE - fx;
      gy = WEIGHT_ONE - fy;
      ch_rd = item.ok ? item.chan : 2'd0;
      is_req = item_valid && item.kind == KIND_REQ;
      do_load = item_valid && item.kind == KIND_LOAD && item.ok;
      wr_addr = mk_addr(item.chan, RW'(item.row), CW'(item.col));
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         mem_a_ff[wr_addr] <= item.pix;
         mem_b_ff[wr_addr] <= item.pix;
      end
      p00_ff <= mem_a_ff[mk_addr(ch_rd, ya, xa)];
      p01_ff <= mem_a_ff[mk_addr(ch_rd, ya, xb)];
      p10_ff <= mem_b_ff[mk_addr(ch_rd, yb, xa)];
      p11_ff <= mem_b_ff[mk_addr(ch_rd, yb, xb)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= is_req;
         s2_v_ff <= s1_v_ff;
      end
      s1_ok_ff <= item.ok;
      s2_ok_ff <= s1_ok_ff;
      w00_ff <= 33'(gx * gy);
      w01_ff <= 33'(fx * gy);
      w10_ff <= 33'(gx * fy);
      w11_ff <= 33'(fx * fy);
      m00_ff <= 41'(w00_ff * p00_ff);
      m01_ff <= 41'(w01_ff * p01_ff);
      m10_ff <= 41'(w10_ff * p10_ff);
      m11_ff <= 41'(w11_ff * p11_ff);
   end

   always_comb begin
      sum = 43'(m00_ff) + 43'(m01_ff) + 43'(m10_ff) + 43'(m11_ff) + ROUND_HALF;
      res = sum[42:32];
      result.valid = s2_v_ff;
      result.pixel = !s2_ok_ff ? 8'd0 : (res > 11'd255) ? 8'd255 : res[7:0];
      inflight = 2'(s1_v_ff) + 2'(s2_v_ff);
   end
endmodule
`default_nettype wire

[src/bilinear_image_resize.sv]
// top level of the bilinear resizer: config registers, queues, front and back
// depends on bir_pkg, bir_queue, bir_front and bir_back
// Sustained rate is one item per clock on both load and request items while
// the result queue is being drained; items stall behind a request when it is
// backed up. A request's result reaches the result queue through the coordinate
// multiplier register, the middle queue, the registered store read and weight
// multiply, and the pixel multiply with the final sum. The store is held in two
// copies with two read ports each so all four neighbours are read in the same
// cycle. Loads are ordered with requests, so a pixel may be requested right
// after it was loaded. The store has no reset and no clearing pass.
`default_nettype none
module bilinear_image_resize #(
   parameter int MAX_SRC_WIDTH = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int CHANNELS = 3
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_push,
   output logic       req_full,
   input  wire        req_kind,
   input  wire [11:0] req_col,
   input  wire [11:0] req_row,
   input  wire [1:0]  req_channel,
   input  wire [7:0]  req_pixel_in,
   output logic       rsp_empty,
   input  wire        rsp_pop,
   output logic [7:0] rsp_pixel_out,
   input  wire        csr_write,
   input  wire [1:0]  csr_index,
   input  wire [23:0] csr_data
);
   import bir_pkg::*;
   localparam int QDEPTH = 4;
   localparam int ODEPTH = 4;
   localparam int QCW = $clog2(QDEPTH+1);
   localparam int OCW = $clog2(ODEPTH+1);

   logic [8:0] src_w_ff, src_h_ff;
   logic [23:0] x_scale_ff, y_scale_ff;
   logic [8:0] size_in;

   logic accept, front_valid, mid_pop, out_pop;
   bir_item_type front_item, mid_item;
   logic [$bits(bir_item_type)-1:0] mid_raw;
   logic [QCW-1:0] mid_count;
   logic [OCW-1:0] out_count;
   bir_result_type result;
   logic [1:0] inflight;

   always_comb begin
      size_in = csr_data[8:0];
      if (size_in == 9'd0) size_in = 9'd1;
   end

   // sizes are stored already clamped to the store dimensions
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= (MAX_SRC_WIDTH < 256) ? 9'(MAX_SRC_WIDTH) : 9'd256;
         src_h_ff <= (MAX_SRC_HEIGHT < 256) ? 9'(MAX_SRC_HEIGHT) : 9'd256;
         x_scale_ff <= 24'd65536;
         y_scale_ff <= 24'd65536;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SRC_WIDTH: begin
               src_w_ff <= (13'(size_in) > 13'(MAX_SRC_WIDTH)) ? 9'(MAX_SRC_WIDTH) : size_in;
            end
            CSR_SRC_HEIGHT: begin
               src_h_ff <= (13'(size_in) > 13'(MAX_SRC_HEIGHT)) ? 9'(MAX_SRC_HEIGHT) : size_in;
            end
            CSR_X_SCALE: x_scale_ff <= csr_data;
            CSR_Y_SCALE: y_scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_full = (QCW'(mid_count + QCW'(front_valid))) >= QCW'(QDEPTH);
   assign accept = req_push && !req_full;

   bir_front #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
               .CHANNELS(CHANNELS)) u_front (
      .clock(clock), .reset(reset), .accept(accept), .kind(req_kind), .col(req_col),
      .row(req_row), .chan(req_channel), .pix(req_pixel_in), .x_scale(x_scale_ff),
      .y_scale(y_scale_ff), .item_valid(front_valid), .item(front_item)
   );

   bir_queue #(.WIDTH($bits(bir_item_type)), .DEPTH(QDEPTH)) u_mid (
      .clock(clock), .reset(reset), .push(front_valid), .push_data(front_item),
      .pop(mid_pop), .pop_data(mid_raw), .count(mid_count)
   );
   assign mid_item = bir_item_type'(mid_raw);

   // a request leaves the queue only when the result queue has a slot reserved
   assign mid_pop = (mid_count != '0) && (mid_item.kind == KIND_LOAD ||
                    (4'(out_count) + 4'(inflight)) < 4'(ODEPTH));

   bir_back #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
              .CHANNELS(CHANNELS)) u_back (
      .clock(clock), .reset(reset), .item_valid(mid_pop), .item(mid_item),
      .src_w(src_w_ff), .src_h(src_h_ff), .result(result), .inflight(inflight)
   );

   assign rsp_empty = (out_count == '0);
   assign out_pop = rsp_pop && !rsp_empty;

   bir_queue #(.WIDTH(8), .DEPTH(ODEPTH)) u_out (
      .clock(clock), .reset(reset), .push(result.valid), .push_data(result.pixel),
      .pop(out_pop), .pop_data(rsp_pixel_out), .count(out_count)
   );

   a_mid_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (front_valid && !mid_pop) |-> (mid_count != QCW'(QDEPTH)))
      else $error("middle queue overflow");
   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (result.valid && !out_pop) |-> (out_count != OCW'(ODEPTH)))
      else $error("result queue overflow");
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result present after reset");
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (4'(out_count) + 4'(inflight)) <= 4'(ODEPTH))
      else $error("more results in flight than slots");
endmodule
`default_nettype wire

[sim/bilinear_image_resize_tb.sv]
// testbench for bilinear_image_resize: loads source pixels, requests resized pixels
// and checks them against a scoreboard that recomputes the interpolation
// depends on bir_pkg and the bilinear_image_resize top level
`timescale 1ns / 1ps
`default_nettype none
module bilinear_image_resize_tb;
   import bir_pkg::*;

   localparam int MAX_W = 256;
   localparam int MAX_H = 256;
   localparam int NUM_CH = 3;
   localparam int STORE_DEPTH = NUM_CH * MAX_H * MAX_W;
   localparam int CYCLE_LIMIT = 400000;

   class resize_scoreboard;
      byte unsigned pixels[STORE_DEPTH];
      bit           written[STORE_DEPTH];
      int unsigned  width_reg = 256, height_reg = 256;
      int unsigned  xscale_reg = 65536, yscale_reg = 65536;
      byte unsigned expected_pixels[$];
      int           errors = 0;

      function int unsigned eff_size(int unsigned v, int unsigned maxv);
         if (v == 0) return 1;
         if (v > maxv) return maxv;
         return v;
      endfunction

      function void write_reg(logic [1:0] idx, logic [23:0] data);
         case (idx)
            CSR_SRC_WIDTH: begin
               width_reg = data[8:0];
            end
            CSR_SRC_HEIGHT: begin
               height_reg = data[8:0];
            end
            CSR_X_SCALE: begin
               xscale_reg = data;
            end
            default: begin
               yscale_reg = data;
            end
         endcase
      endfunction

      // floor of the source coordinate and its Q0.16 fraction
      function void map_coord(int unsigned dst, int unsigned scale, output longint base,
                              output longint unsigned frac);
         longint unsigned t;
         t = (longint'(2 * dst + 1)) * longint'(scale) + 65536;
         base = longint'(t >> 17) - 1;
         frac = (t & 64'h1FFFF) >> 1;
      endfunction

      function int unsigned clamp(longint v, int unsigned size);
         if (v < 0) return 0;
         if (v >= size) return size - 1;
         return 32'(v);
      endfunction

      // store indexes of the four neighbours, in weight order
      function void corners(int unsigned col, int unsigned row, int unsigned ch,
                            output int unsigned idx[4], output longint unsigned fx,
                            output longint unsigned fy);
         longint bx, by;
         int unsigned xa, xb, ya, yb;
         map_coord(col, xscale_reg, bx, fx);
         map_coord(row, yscale_reg, by, fy);
         xa = clamp(bx, eff_size(width_reg, MAX_W));
         xb = clamp(bx + 1, eff_size(width_reg, MAX_W));
         ya = clamp(by, eff_size(height_reg, MAX_H));
         yb = clamp(by + 1, eff_size(height_reg, MAX_H));
         idx[0] = (ch * MAX_H + ya) * MAX_W + xa;
         idx[1] = (ch * MAX_H + ya) * MAX_W + xb;
         idx[2] = (ch * MAX_H + yb) * MAX_W + xa;
         idx[3] = (ch * MAX_H + yb) * MAX_W + xb;
      endfunction

      function byte unsigned interpolate(int unsigned col, int unsigned row, int unsigned ch);
         int unsigned idx[4];
         longint unsigned fx, fy, gx, gy, acc;
         if (ch >= NUM_CH) return 0;
         corners(col, row, ch, idx, fx, fy);
         gx = 65536 - fx;
         gy = 65536 - fy;
         acc = gx * gy * pixels[idx[0]] + fx * gy * pixels[idx[1]]
             + gx * fy * pixels[idx[2]] + fx * fy * pixels[idx[3]];
         acc = (acc + 64'h8000_0000) >> 32;
         if (acc > 255) acc = 255;
         return acc[7:0];
      endfunction

      function void note_transfer(logic kind, logic [11:0] col, logic [11:0] row,
                                  logic [1:0] ch, logic [7:0] pix);
         int unsigned a;
         if (kind == KIND_LOAD) begin
            if (col < MAX_W && row < MAX_H && ch < NUM_CH) begin
               a = (ch * MAX_H + row) * MAX_W + col;
               pixels[a] = pix;
               written[a] = 1'b1;
            end
         end else begin
            expected_pixels.push_back(interpolate(col, row, ch));
         end
      endfunction

      function void check_pixel(logic [7:0] got);
         byte unsigned want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel transfer, actual %0d", $realtime, got);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         if (got !== want) begin
            $display("%0t: pixel_out mismatch, expected %0d, actual %0d", $realtime, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic req_kind = KIND_LOAD;
   logic [11:0] req_col = '0;
   logic [11:0] req_row = '0;
   logic [1:0] req_channel = '0;
   logic [7:0] req_pixel_in = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [7:0] rsp_pixel_out;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_SRC_WIDTH;
   logic [23:0] csr_data = '0;

   resize_scoreboard sb = new();
   int tx_idle_pct = 17;
   int rx_idle_pct = 50;
   int cycles = 0;

   bilinear_image_resize uut (
      .clock, .reset, .req_push, .req_full, .req_kind, .req_col, .req_row,
      .req_channel, .req_pixel_in, .rsp_empty, .rsp_pop, .rsp_pixel_out,
      .csr_write, .csr_index, .csr_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: check on each transfer, then pick the next pop
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_pixel(rsp_pixel_out);
      rsp_pop <= !reset && ($urandom_range(99) >= rx_idle_pct);
   end

   task automatic send_item(logic kind, logic [11:0] col, logic [11:0] row,
                            logic [1:0] ch, logic [7:0] pix);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_kind <= kind;
      req_col <= col;
      req_row <= row;
      req_channel <= ch;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      sb.note_transfer(kind, col, row, ch, pix);
   endtask

   // loads any neighbour not yet written so the request never reads unwritten pixels
   task automatic send_request(logic [11:0] col, logic [11:0] row, logic [1:0] ch);
      int unsigned idx[4];
      longint unsigned fx, fy;
      if (ch < NUM_CH) begin
         sb.corners(col, row, ch, idx, fx, fy);
         foreach (idx[k])
            if (!sb.written[idx[k]])
               send_item(KIND_LOAD, 12'(idx[k] % MAX_W), 12'((idx[k] / MAX_W) % MAX_H),
                         2'(idx[k] / (MAX_W * MAX_H)), 8'($urandom_range(255)));
      end
      send_item(KIND_REQ, col, row, ch, 8'($urandom_range(255)));
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.expected_pixels.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [23:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic setup(int unsigned w, int unsigned h, int unsigned xs, int unsigned ys);
      write_csr(CSR_SRC_WIDTH, 24'(w));
      write_csr(CSR_SRC_HEIGHT, 24'(h));
      write_csr(CSR_X_SCALE, 24'(xs));
      write_csr(CSR_Y_SCALE, 24'(ys));
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_items(int n, int unsigned span);
      logic [11:0] c, r;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 25) begin
            c = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(MAX_W - 1));
            r = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(MAX_H - 1));
            send_item(KIND_LOAD, c, r, 2'($urandom_range(3)), 8'($urandom_range(255)));
         end else begin
            c = ($urandom_range(15) == 0) ? 12'($urandom) : 12'($urandom_range(span));
            r = ($urandom_range(15) == 0) ? 12'($urandom) : 12'($urandom_range(span));
            send_request(c, r, ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, extremes of loads and requests
      send_item(KIND_LOAD, 0, 0, 0, 8'd0);
      send_item(KIND_LOAD, 255, 255, 2, 8'd255);
      send_item(KIND_LOAD, 12'hFFF, 0, 0, 8'hAA);
      send_item(KIND_LOAD, 0, 12'hFFF, 1, 8'h55);
      send_item(KIND_LOAD, 3, 3, 3, 8'hFF);
      send_request(0, 0, 0);
      send_request(255, 255, 2);
      send_request(12'hFFF, 12'hFFF, 1);
      send_request(7, 9, 3);
      drain();
      // zero scale and degenerate source size
      setup(0, 1, 0, 0);
      send_request(12'hFFF, 5, 0);
      send_request(0, 0, 1);
      drain();
      // oversized source and the largest scale; upper data bits set
      setup(24'hFFFF_FF, 24'hFFFE_FF, 24'hFF_FFFF, 24'hFF_FFFF);
      send_request(0, 0, 2);
      send_request(12'hFFF, 12'hFFF, 0);
      send_request(1, 0, 1);
      drain();

      for (int p = 0; p < 6; p++) begin
         int unsigned w, h;
         tx_idle_pct = (p < 2) ? 17 : (p < 4) ? 50 : 0;
         rx_idle_pct = (p < 2) ? 50 : (p < 4) ? 17 : 0;
         w = (p == 5) ? 256 : $urandom_range(2, 24);
         h = (p == 4) ? 1 : $urandom_range(2, 24);
         setup(w, h, $urandom_range(16384, 262144), $urandom_range(16384, 262144));
         random_items(250, 2 * ((w > h) ? w : h));
         drain();
      end

      if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
